// ===== rtl/mlp_pkg.sv =====
// shared types, byte codes and result codes for the metric line parser
`default_nettype none

package mlp_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 10;
    localparam int KIND_W   = 2;
    localparam int TOTAL_W  = 32;

    localparam logic [LEN_W-1:0] LEN_MAX       = '1;
    localparam logic [LEN_W-1:0] MAX_PATH_INIT = '1;

    // byte codes
    localparam logic [BYTE_W-1:0] C_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] C_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] C_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] C_BAR   = 8'h7C;
    localparam logic [BYTE_W-1:0] C_CH_C  = 8'h63;
    localparam logic [BYTE_W-1:0] C_CH_M  = 8'h6D;
    localparam logic [BYTE_W-1:0] C_CH_G  = 8'h67;

    localparam int KA_LEN = 9;

    // line status codes
    localparam logic [STATUS_W-1:0] ST_POINT     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_KEEPALIVE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;

    // metric kind codes
    localparam logic [KIND_W-1:0] KIND_COUNTER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TIMER   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GAUGE   = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_byte_slot;

    typedef struct packed {
        logic [STATUS_W-1:0] line_status;
        logic [LEN_W-1:0]    path_length;
        logic [LEN_W-1:0]    value_length;
        logic [KIND_W-1:0]   metric_kind;
        logic [TOTAL_W-1:0]  point_total;
        logic [TOTAL_W-1:0]  invalid_total;
    } t_result;

    // expected byte of the keepalive word at a given position
    function automatic logic [BYTE_W-1:0] f_ka_char(input logic [3:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            4'd0:    c = 8'h6B;
            4'd1:    c = 8'h65;
            4'd2:    c = 8'h65;
            4'd3:    c = 8'h70;
            4'd4:    c = 8'h61;
            4'd5:    c = 8'h6C;
            4'd6:    c = 8'h69;
            4'd7:    c = 8'h76;
            4'd8:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mlp_ifs.sv =====
// valid/ready channel interfaces for the byte input and the line result output
`default_nettype none

interface mlp_in_if;
    import mlp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mlp_out_if;
    import mlp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] line_status;
    logic [LEN_W-1:0]    path_length;
    logic [LEN_W-1:0]    value_length;
    logic [KIND_W-1:0]   metric_kind;
    logic [TOTAL_W-1:0]  point_total;
    logic [TOTAL_W-1:0]  invalid_total;

    modport source (output valid, output line_status, output path_length,
                    output value_length, output metric_kind, output point_total,
                    output invalid_total, input ready);
    modport sink   (input valid, input line_status, input path_length,
                    input value_length, input metric_kind, input point_total,
                    input invalid_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/mlp_in_stage.sv =====
// input register that holds one accepted byte until the line core takes it
`default_nettype none

module mlp_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    mlp_in_if.sink              i_byte,
    input  wire                 i_take,
    output mlp_pkg::t_byte_slot o_slot
);
    import mlp_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_data;
    logic              accept;

    assign i_byte.ready = !r_valid || i_take;
    assign accept       = i_byte.valid && i_byte.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= i_byte.data_byte;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/mlp_line_core.sv =====
// per-line parse state, line classification and running totals
`default_nettype none

module mlp_line_core #(
    parameter int LINE_MAX_BYTES = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mlp_pkg::t_byte_slot          i_slot,
    input  wire                          i_space,
    input  wire                          i_cfg_we,
    input  wire [mlp_pkg::LEN_W-1:0]     i_cfg_data,
    output logic                         o_take,
    output logic                         o_load,
    output mlp_pkg::t_result             o_result
);
    import mlp_pkg::*;

    localparam int PW = $clog2(LINE_MAX_BYTES + 1);
    localparam int CW = (PW > LEN_W) ? PW : LEN_W;

    typedef struct packed {
        logic [PW-1:0]     pos;
        logic              lead_skip;
        logic              held_cr;
        logic              colon_found;
        logic [PW-1:0]     colon_pos;
        logic              bar_found;
        logic [PW-1:0]     bar_pos;
        logic [BYTE_W-1:0] type_byte;
        logic              ka_match;
        logic              overflow;
    } t_line;

    localparam t_line LINE_CLEAR = '{
        pos: '0, lead_skip: 1'b0, held_cr: 1'b0, colon_found: 1'b0,
        colon_pos: '0, bar_found: 1'b0, bar_pos: '0, type_byte: '0,
        ka_match: 1'b1, overflow: 1'b0
    };

    t_line              r_line;
    t_line              n_line;
    logic [TOTAL_W-1:0] r_point_cnt;
    logic [TOTAL_W-1:0] n_point_cnt;
    logic [TOTAL_W-1:0] r_invalid_cnt;
    logic [TOTAL_W-1:0] n_invalid_cnt;
    logic [LEN_W-1:0]   r_max_path;

    logic               is_lf;
    logic               produce;
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]  kind;
    logic [LEN_W-1:0]   plen;
    logic [LEN_W-1:0]   vlen;
    logic [PW-1:0]      vdiff;
    logic [CW-1:0]      vdiff_ext;
    logic [CW-1:0]      colon_ext;
    t_line              stepped;

    // one content byte into the line state
    function automatic t_line f_take(input t_line s, input logic [BYTE_W-1:0] b);
        t_line t;
        t = s;
        if (s.pos >= PW'(LINE_MAX_BYTES)) begin
            t.overflow = 1'b1;
        end else begin
            if (s.pos < PW'(KA_LEN)) begin
                if (b != f_ka_char(s.pos[3:0])) begin
                    t.ka_match = 1'b0;
                end
            end else begin
                t.ka_match = 1'b0;
            end
            if (!s.colon_found) begin
                if (b == C_COLON) begin
                    t.colon_found = 1'b1;
                    t.colon_pos   = s.pos;
                end
            end else if (!s.bar_found) begin
                if (b == C_BAR) begin
                    t.bar_found = 1'b1;
                    t.bar_pos   = s.pos;
                end
            end else if (s.pos == s.bar_pos + PW'(1)) begin
                t.type_byte = b;
            end
            t.pos = s.pos + PW'(1);
        end
        return t;
    endfunction

    assign is_lf     = (i_slot.data == C_LF);
    assign produce   = is_lf && (r_line.pos != '0);
    assign o_take    = i_slot.valid && (!produce || i_space);
    assign o_load    = i_slot.valid && produce && i_space;

    assign colon_ext = CW'(r_line.colon_pos);
    assign vdiff     = r_line.bar_pos - r_line.colon_pos - PW'(1);
    assign vdiff_ext = CW'(vdiff);

    // classification of the finished line
    always_comb begin
        status = ST_INVALID;
        kind   = KIND_COUNTER;
        plen   = '0;
        vlen   = '0;
        if (r_line.overflow) begin
            status = ST_INVALID;
        end else if (!r_line.colon_found) begin
            if (r_line.pos == PW'(KA_LEN) && r_line.ka_match) begin
                status = ST_KEEPALIVE;
            end
        end else if (r_line.colon_pos == '0 ||
                     r_line.colon_pos + PW'(1) >= r_line.pos) begin
            status = ST_INVALID;
        end else if (!r_line.bar_found) begin
            status = ST_INVALID;
        end else if (colon_ext > CW'(r_max_path)) begin
            status = ST_INVALID;
        end else begin
            case (r_line.type_byte)
                C_CH_C: begin
                    status = ST_POINT;
                    kind   = KIND_COUNTER;
                end
                C_CH_M: begin
                    status = ST_POINT;
                    kind   = KIND_TIMER;
                end
                C_CH_G: begin
                    status = ST_POINT;
                    kind   = KIND_GAUGE;
                end
                default: begin
                    status = ST_INVALID;
                end
            endcase
            if (status == ST_POINT) begin
                plen = LEN_W'(colon_ext);
                vlen = (vdiff_ext > CW'(LEN_MAX)) ? LEN_MAX : LEN_W'(vdiff_ext);
            end
        end
    end

    // line state after a non-newline byte; a held cr turns out to be content
    always_comb begin
        stepped = r_line;
        if (stepped.held_cr) begin
            stepped.held_cr = 1'b0;
            stepped = f_take(stepped, C_CR);
        end
        if (i_slot.data == C_CR) begin
            if (stepped.pos == '0 && !stepped.lead_skip) begin
                stepped.lead_skip = 1'b1;
            end else begin
                stepped.held_cr = 1'b1;
            end
        end else begin
            stepped.lead_skip = 1'b1;
            stepped = f_take(stepped, i_slot.data);
        end
    end

    always_comb begin
        n_line        = r_line;
        n_point_cnt   = r_point_cnt;
        n_invalid_cnt = r_invalid_cnt;
        if (o_take) begin
            if (is_lf) begin
                n_line = LINE_CLEAR;
                if (produce) begin
                    if (status == ST_POINT) begin
                        n_point_cnt = r_point_cnt + TOTAL_W'(1);
                    end else if (status == ST_INVALID) begin
                        n_invalid_cnt = r_invalid_cnt + TOTAL_W'(1);
                    end
                end
            end else begin
                n_line = stepped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line        <= LINE_CLEAR;
            r_point_cnt   <= '0;
            r_invalid_cnt <= '0;
            r_max_path    <= MAX_PATH_INIT;
        end else begin
            r_line        <= n_line;
            r_point_cnt   <= n_point_cnt;
            r_invalid_cnt <= n_invalid_cnt;
            if (i_cfg_we) begin
                r_max_path <= i_cfg_data;
            end
        end
    end

    assign o_result.line_status   = status;
    assign o_result.path_length   = plen;
    assign o_result.value_length  = vlen;
    assign o_result.metric_kind   = kind;
    assign o_result.point_total   = n_point_cnt;
    assign o_result.invalid_total = n_invalid_cnt;

endmodule

`default_nettype wire

// ===== rtl/mlp_out_stage.sv =====
// result register that holds one line result until it is taken
`default_nettype none

module mlp_out_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_load,
    input  mlp_pkg::t_result i_result,
    output logic             o_space,
    mlp_out_if.source        o_line
);
    import mlp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_space = !r_valid || o_line.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_line.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_line.valid         = r_valid;
    assign o_line.line_status   = r_result.line_status;
    assign o_line.path_length   = r_result.path_length;
    assign o_line.value_length  = r_result.value_length;
    assign o_line.metric_kind   = r_result.metric_kind;
    assign o_line.point_total   = r_result.point_total;
    assign o_line.invalid_total = r_result.invalid_total;

endmodule

`default_nettype wire

// ===== rtl/metric_line_parser.sv =====
// top level of the metric line parser
// Takes one text byte per cycle on i_byte and gives one result on o_line for every
// non-empty line ended by a newline: metric point (path:value|type with type c, m
// or g), keepalive, or invalid. A transferred byte sits in an input register and
// is parsed from there by compare-and-count logic; a line result is loaded into
// the result register, which drives o_line. The sustained rate is one byte per
// cycle; i_byte.ready drops only while a newline waits in the input register and
// the result register is still held by a stalled o_line. i_cfg_we writes
// max_path_length from i_cfg_data (reset 1023). LINE_MAX_BYTES sets the longest
// line kept; longer lines are reported invalid.
`default_nettype none

module metric_line_parser #(
    parameter int LINE_MAX_BYTES = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    mlp_in_if.sink                   i_byte,
    mlp_out_if.source                o_line,
    input  wire                      i_cfg_we,
    input  wire [mlp_pkg::LEN_W-1:0] i_cfg_data
);
    import mlp_pkg::*;

    t_byte_slot slot;
    t_result    result;
    logic       take;
    logic       load;
    logic       space;

    mlp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (take),
        .o_slot  (slot)
    );

    mlp_line_core #(
        .LINE_MAX_BYTES (LINE_MAX_BYTES)
    ) u_line_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_slot     (slot),
        .i_space    (space),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_take     (take),
        .o_load     (load),
        .o_result   (result)
    );

    mlp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (result),
        .o_space  (space),
        .o_line   (o_line)
    );

endmodule

`default_nettype wire

// ===== rtl/mlp_checker.sv =====
// port-level checks on the metric line parser, bound to the top level
`default_nettype none

module mlp_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_out_valid,
    input wire                        i_out_ready,
    input wire [mlp_pkg::STATUS_W-1:0] i_out_status,
    input wire [mlp_pkg::LEN_W-1:0]   i_out_plen,
    input wire [mlp_pkg::LEN_W-1:0]   i_out_vlen,
    input wire [mlp_pkg::KIND_W-1:0]  i_out_kind,
    input wire [mlp_pkg::TOTAL_W-1:0] i_out_point,
    input wire [mlp_pkg::TOTAL_W-1:0] i_out_invalid
);
    import mlp_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status) &&
        $stable(i_out_plen) && $stable(i_out_vlen) && $stable(i_out_kind) &&
        $stable(i_out_point) && $stable(i_out_invalid))
        else $error("stalled result changed");

    // lengths and kind only carry meaning for a metric point
    a_non_point_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_POINT |->
        i_out_plen == '0 && i_out_vlen == '0 && i_out_kind == KIND_COUNTER)
        else $error("non-point result carries lengths or kind");

    // a point always has a non-empty path
    a_point_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_POINT |-> i_out_plen != '0)
        else $error("point with empty path");

endmodule

bind metric_line_parser mlp_checker u_mlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_line.valid),
    .i_out_ready   (o_line.ready),
    .i_out_status  (o_line.line_status),
    .i_out_plen    (o_line.path_length),
    .i_out_vlen    (o_line.value_length),
    .i_out_kind    (o_line.metric_kind),
    .i_out_point   (o_line.point_total),
    .i_out_invalid (o_line.invalid_total)
);

`default_nettype wire
